>>> rtl/terminal_key_decoder_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the terminal key decoder
// Concurrent checks; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef TERMINAL_KEY_DECODER_UNIT_MACROS_SVH
`define TERMINAL_KEY_DECODER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// property holds at every clock edge out of reset
`define TKD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define TKD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define TKD_ASSERT(label, clk, rst_n, prop, msg)
`define TKD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> rtl/tkd_pkg.sv
// ----------------------------------------------------------------------------
// tkd_pkg
// Types and constants of the terminal key decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tkd_pkg;

  localparam int unsigned KeyW   = 22;
  localparam int unsigned CodeW  = 21;
  localparam int unsigned ByteW  = 8;

  typedef logic signed [KeyW-1:0] key_t;

  typedef enum logic [1:0] {
    MODE_BYTE    = 2'd0,
    MODE_TIMEOUT = 2'd1,
    MODE_EOF     = 2'd2,
    MODE_NONE    = 2'd3
  } mode_e;

  // input characters of interest
  localparam logic [ByteW-1:0] CH_ESC   = 8'h1B;
  localparam logic [ByteW-1:0] CH_O     = 8'h4F;
  localparam logic [ByteW-1:0] CH_BR    = 8'h5B;
  localparam logic [ByteW-1:0] CH_TILDE = 8'h7E;
  localparam logic [ByteW-1:0] CH_ZERO  = 8'h30;
  localparam logic [ByteW-1:0] CH_NINE  = 8'h39;

  // key codes
  localparam key_t KEY_REPLACE  = 22'sh00FFFD;
  localparam key_t KEY_LONE_ESC = 22'sd27;
  localparam key_t KEY_SS3      = -22'sh200;
  localparam key_t KEY_CSI_SS3  = -22'sh300;
  localparam key_t KEY_CSI_BR   = -22'sh400;
  localparam key_t KEY_CSI      = -22'sh500;
  localparam key_t KEY_CSI_TLD  = -22'sh600;
  localparam key_t KEY_CSI_NUM  = -22'sh700;
  localparam key_t KEY_ALT      = -22'sh800;

endpackage

>>> rtl/terminal_key_decoder_unit.sv
// ----------------------------------------------------------------------------
// terminal_key_decoder_unit
// Decodes terminal input events (byte, idle timeout, end of input) into UTF-8
// code points and negative escape-sequence key codes.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake               Payload
// in       sink       in_valid_i / in_stall_o    mode_i, data_byte_i
// out      source     out_valid_o / out_stall_i  key_code_o, end_of_input_o
//
// One item per cycle sustained while the output does not stall.
// Input register, one pass of parser logic, then the result register; the
// parser state updates as an item leaves the input register.
// Items that yield no key leave no result.
// Reset clears the parser state and both valid flags.
// A stalled result holds the input register; further items then stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "terminal_key_decoder_unit_macros.svh"

module terminal_key_decoder_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    mode_i,
  input  logic [tkd_pkg::ByteW-1:0]     data_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [tkd_pkg::KeyW-1:0] key_code_o,
  output logic                          end_of_input_o
);

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_UTF8    = 3'd1,
    PH_ESC     = 3'd2,
    PH_ESC_O   = 3'd3,
    PH_CSI     = 3'd4,
    PH_CSI_O   = 3'd5,
    PH_CSI_BR  = 3'd6,
    PH_CSI_NUM = 3'd7
  } phase_e;

  // input register
  logic                        s0_valid_q, s0_valid_d;
  tkd_pkg::mode_e              mode_q;
  logic [tkd_pkg::ByteW-1:0]   byte_q;

  // parser state
  phase_e                      phase_q, phase_d;
  logic [1:0]                  rem_q, rem_d;
  logic [tkd_pkg::CodeW-1:0]   part_q, part_d;
  logic [7:0]                  num_q, num_d;

  // result register
  logic                        out_valid_q, out_valid_d;
  tkd_pkg::key_t               key_q;
  logic                        eof_q;

  logic                        out_free, s0_fire, in_accept;
  logic                        res_valid, res_eof, fin;
  tkd_pkg::key_t               res_key;
  logic                        is_digit;
  logic [11:0]                 num_ext, num_sum;
  logic [tkd_pkg::CodeW-1:0]   part_shift;

  assign out_free    = ~out_valid_q | ~out_stall_i;
  assign s0_fire     = s0_valid_q & out_free;
  assign in_stall_o  = s0_valid_q & ~out_free;
  assign in_accept   = in_valid_i & ~in_stall_o;
  assign s0_valid_d  = in_accept | (s0_valid_q & ~s0_fire);

  assign is_digit    = (byte_q >= tkd_pkg::CH_ZERO) && (byte_q <= tkd_pkg::CH_NINE);
  assign num_ext     = {4'b0, num_q};
  assign num_sum     = (num_ext << 3) + (num_ext << 1) + {8'b0, byte_q[3:0]};
  assign part_shift  = {part_q[tkd_pkg::CodeW-7:0], byte_q[5:0]};

  always_comb begin
    phase_d   = phase_q;
    rem_d     = rem_q;
    part_d    = part_q;
    num_d     = num_q;
    res_valid = 1'b0;
    res_eof   = 1'b0;
    res_key   = '0;
    fin       = 1'b0;
    if (s0_fire) begin
      unique case (mode_q)
        tkd_pkg::MODE_EOF: begin
          res_valid = 1'b1;
          res_eof   = 1'b1;
          fin       = 1'b1;
        end
        tkd_pkg::MODE_TIMEOUT: begin
          if (phase_q == PH_ESC) begin
            fin     = 1'b1;
            res_key = tkd_pkg::KEY_LONE_ESC;
          end
        end
        tkd_pkg::MODE_BYTE: begin
          unique case (phase_q)
            PH_IDLE: begin
              if (byte_q[7]) begin
                priority if (byte_q[7:5] == 3'b110) begin
                  rem_d   = 2'd1;
                  part_d  = {16'b0, byte_q[4:0]};
                  phase_d = PH_UTF8;
                end else if (byte_q[7:4] == 4'b1110) begin
                  rem_d   = 2'd2;
                  part_d  = {17'b0, byte_q[3:0]};
                  phase_d = PH_UTF8;
                end else if (byte_q[7:3] == 5'b11110) begin
                  rem_d   = 2'd3;
                  part_d  = {18'b0, byte_q[2:0]};
                  phase_d = PH_UTF8;
                end else begin
                  fin     = 1'b1;
                  res_key = tkd_pkg::KEY_REPLACE;
                end
              end else if (byte_q == tkd_pkg::CH_ESC) begin
                phase_d = PH_ESC;
              end else begin
                fin     = 1'b1;
                res_key = {14'b0, byte_q};
              end
            end
            PH_UTF8: begin
              if (byte_q[7:6] != 2'b10) begin
                fin     = 1'b1;
                res_key = tkd_pkg::KEY_REPLACE;
              end else begin
                part_d = part_shift;
                rem_d  = rem_q - 2'd1;
                if (rem_q == 2'd1) begin
                  fin     = 1'b1;
                  res_key = {1'b0, part_shift};
                end
              end
            end
            PH_ESC: begin
              priority if (byte_q == tkd_pkg::CH_O) begin
                phase_d = PH_ESC_O;
              end else if (byte_q == tkd_pkg::CH_BR) begin
                phase_d = PH_CSI;
              end else begin
                fin     = 1'b1;
                res_key = tkd_pkg::KEY_ALT + {14'b0, byte_q};
              end
            end
            PH_ESC_O: begin
              fin     = 1'b1;
              res_key = tkd_pkg::KEY_SS3 + {14'b0, byte_q};
            end
            PH_CSI: begin
              priority if (byte_q == tkd_pkg::CH_O) begin
                phase_d = PH_CSI_O;
              end else if (byte_q == tkd_pkg::CH_BR) begin
                phase_d = PH_CSI_BR;
              end else if (is_digit) begin
                num_d   = {4'b0, byte_q[3:0]};
                phase_d = PH_CSI_NUM;
              end else begin
                fin     = 1'b1;
                res_key = tkd_pkg::KEY_CSI + {14'b0, byte_q};
              end
            end
            PH_CSI_O: begin
              fin     = 1'b1;
              res_key = tkd_pkg::KEY_CSI_SS3 + {14'b0, byte_q};
            end
            PH_CSI_BR: begin
              fin     = 1'b1;
              res_key = tkd_pkg::KEY_CSI_BR + {14'b0, byte_q};
            end
            PH_CSI_NUM: begin
              priority if (is_digit) begin
                num_d = (num_sum > 12'd255) ? 8'hFF : num_sum[7:0];
              end else if (byte_q == tkd_pkg::CH_TILDE) begin
                fin     = 1'b1;
                res_key = tkd_pkg::KEY_CSI_TLD + {14'b0, num_q};
              end else begin
                fin     = 1'b1;
                res_key = tkd_pkg::KEY_CSI_NUM + {14'b0, num_q};
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
      if (fin) begin
        res_valid = 1'b1;
        phase_d   = PH_IDLE;
        rem_d     = '0;
        part_d    = '0;
        num_d     = '0;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q & out_stall_i;
    if (res_valid) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PH_IDLE;
      rem_q       <= '0;
      part_q      <= '0;
      num_q       <= '0;
    end else begin
      s0_valid_q  <= s0_valid_d;
      out_valid_q <= out_valid_d;
      phase_q     <= phase_d;
      rem_q       <= rem_d;
      part_q      <= part_d;
      num_q       <= num_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      mode_q <= tkd_pkg::mode_e'(mode_i);
      byte_q <= data_byte_i;
    end
    if (res_valid) begin
      key_q <= res_key;
      eof_q <= res_eof;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign key_code_o     = key_q;
  assign end_of_input_o = eof_q;

  `TKD_ASSERT(a_eof_zero_key, clk_i, rst_ni,
    !(out_valid_q && eof_q) || (key_q == '0), "end of input with nonzero key code")
  `TKD_ASSERT(a_utf8_count, clk_i, rst_ni,
    (phase_q != PH_UTF8) || (rem_q != 2'd0), "UTF-8 phase with no bytes remaining")
  `TKD_ASSERT(a_num_phase, clk_i, rst_ni,
    (phase_q == PH_CSI_NUM) || (num_q == 8'd0), "number held outside numeric phase")
  `TKD_ASSERT_NEXT(a_eof_idle, clk_i, rst_ni,
    s0_fire && (mode_q == tkd_pkg::MODE_EOF), (phase_q == PH_IDLE) && out_valid_q,
    "end of input did not reset the parser")
  `TKD_ASSERT(a_stall_held, clk_i, rst_ni,
    !in_stall_o || (s0_valid_q && out_valid_q), "input stalled with room downstream")

endmodule

>>> bench/terminal_key_decoder_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// terminal_key_decoder_unit_checker
// Watches both channels of the key decoder. Each accepted item runs through
// a local model of the parser and any key it yields is queued. Each accepted
// result is compared against the oldest queued key.
// ----------------------------------------------------------------------------

module terminal_key_decoder_unit_checker
  import tkd_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_stall_i,
  input  logic [1:0]             mode_i,
  input  logic [ByteW-1:0]       data_byte_i,
  input  logic                   out_valid_i,
  input  logic                   out_stall_i,
  input  logic signed [KeyW-1:0] key_code_i,
  input  logic                   end_of_input_i,
  output int                     fail_count_o,
  output int                     awaited_count_o
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_UTF8, PH_ESC, PH_ESC_O, PH_CSI, PH_CSI_O, PH_CSI_BR, PH_CSI_NUM
  } phase_e;

  typedef struct packed {
    key_t key;
    logic eof;
  } key_rec_t;

  phase_e           phase;
  logic [1:0]       cont_left;
  logic [CodeW-1:0] code_acc;
  logic [7:0]       csi_num;

  key_rec_t awaited_keys[$];
  key_rec_t want_rec;
  key_rec_t next_rec;
  bit       emits;
  int       fails;

  task automatic clear_parser();
    phase     = PH_IDLE;
    cont_left = '0;
    code_acc  = '0;
    csi_num   = '0;
  endtask

  function automatic bit is_digit(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  // advances the local parser by one item; yields the key it completes, if any
  task automatic decode_event(input mode_e m, input logic [7:0] b,
                              output bit yields, output key_rec_t rec);
    bit   done;
    bit   eof;
    key_t k;
    key_t bk;
    int   acc;
    done = 1'b0;
    eof  = 1'b0;
    k    = '0;
    bk   = key_t'({14'd0, b});
    case (m)
      MODE_EOF: begin
        done = 1'b1;
        eof  = 1'b1;
      end
      MODE_TIMEOUT: begin
        if (phase == PH_ESC) begin
          done = 1'b1;
          k    = KEY_LONE_ESC;
        end
      end
      MODE_BYTE: begin
        case (phase)
          PH_IDLE: begin
            if (b[7]) begin
              if (b[7:5] == 3'b110) begin
                cont_left = 2'd1;
                code_acc  = CodeW'(b[4:0]);
                phase     = PH_UTF8;
              end else if (b[7:4] == 4'b1110) begin
                cont_left = 2'd2;
                code_acc  = CodeW'(b[3:0]);
                phase     = PH_UTF8;
              end else if (b[7:3] == 5'b11110) begin
                cont_left = 2'd3;
                code_acc  = CodeW'(b[2:0]);
                phase     = PH_UTF8;
              end else begin
                done = 1'b1;
                k    = KEY_REPLACE;
              end
            end else if (b == CH_ESC) begin
              phase = PH_ESC;
            end else begin
              done = 1'b1;
              k    = bk;
            end
          end
          PH_UTF8: begin
            if (b[7:6] != 2'b10) begin
              done = 1'b1;
              k    = KEY_REPLACE;
            end else begin
              code_acc  = {code_acc[CodeW-7:0], b[5:0]};
              cont_left = cont_left - 2'd1;
              if (cont_left == 2'd0) begin
                done = 1'b1;
                k    = key_t'({1'b0, code_acc});
              end
            end
          end
          PH_ESC: begin
            if (b == CH_O) begin
              phase = PH_ESC_O;
            end else if (b == CH_BR) begin
              phase = PH_CSI;
            end else begin
              done = 1'b1;
              k    = KEY_ALT + bk;
            end
          end
          PH_ESC_O: begin
            done = 1'b1;
            k    = KEY_SS3 + bk;
          end
          PH_CSI: begin
            if (b == CH_O) begin
              phase = PH_CSI_O;
            end else if (b == CH_BR) begin
              phase = PH_CSI_BR;
            end else if (is_digit(b)) begin
              csi_num = b - CH_ZERO;
              phase   = PH_CSI_NUM;
            end else begin
              done = 1'b1;
              k    = KEY_CSI + bk;
            end
          end
          PH_CSI_O: begin
            done = 1'b1;
            k    = KEY_CSI_SS3 + bk;
          end
          PH_CSI_BR: begin
            done = 1'b1;
            k    = KEY_CSI_BR + bk;
          end
          default: begin
            if (is_digit(b)) begin
              acc     = int'(csi_num) * 10 + int'(b - CH_ZERO);
              csi_num = (acc > 255) ? 8'd255 : 8'(acc);
            end else begin
              done = 1'b1;
              k    = ((b == CH_TILDE) ? KEY_CSI_TLD : KEY_CSI_NUM) + key_t'({14'd0, csi_num});
            end
          end
        endcase
      end
      default: ;
    endcase
    if (done) clear_parser();
    yields = done;
    rec    = '{key: k, eof: eof};
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parser();
      awaited_keys.delete();
      fails = 0;
      fail_count_o    <= 0;
      awaited_count_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (awaited_keys.size() == 0) begin
          fails++;
          $display("%0t: unexpected result: expected none, actual key_code %0d eof %0b",
                   $time, key_code_i, end_of_input_i);
        end else begin
          want_rec = awaited_keys.pop_front();
          if (want_rec.key !== key_code_i) begin
            fails++;
            $display("%0t: key_code expected %0d actual %0d",
                     $time, $signed(want_rec.key), key_code_i);
          end
          if (want_rec.eof !== end_of_input_i) begin
            fails++;
            $display("%0t: end_of_input expected %0b actual %0b",
                     $time, want_rec.eof, end_of_input_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        decode_event(mode_e'(mode_i), data_byte_i, emits, next_rec);
        if (emits) awaited_keys.push_back(next_rec);
      end
      fail_count_o    <= fails;
      awaited_count_o <= awaited_keys.size();
    end
  end

endmodule

>>> bench/terminal_key_decoder_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// terminal_key_decoder_unit_tb
// Drives the key decoder with a directed set of key sequences, then with
// random well-formed and broken UTF-8 and escape sequences, bursty on the
// input side and with random back-pressure on the output side.
// ----------------------------------------------------------------------------

module terminal_key_decoder_unit_tb;
  import tkd_pkg::*;

  localparam int ITEMS       = 1550;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 400000;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic [1:0]             mode_i;
  logic [ByteW-1:0]       data_byte_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic signed [KeyW-1:0] key_code_o;
  logic                   end_of_input_o;

  int          fail_count;
  int          awaited_count;
  int          cycle_count = 0;
  int          items_sent  = 0;
  int unsigned burst_left  = 0;
  int          hold_ask    = 0;
  int          hold_served = 0;

  always #5 clk_i = ~clk_i;

  terminal_key_decoder_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .mode_i        (mode_i),
    .data_byte_i   (data_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .key_code_o    (key_code_o),
    .end_of_input_o(end_of_input_o)
  );

  terminal_key_decoder_unit_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .mode_i         (mode_i),
    .data_byte_i    (data_byte_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .key_code_i     (key_code_o),
    .end_of_input_i (end_of_input_o),
    .fail_count_o   (fail_count),
    .awaited_count_o(awaited_count)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("terminal_key_decoder_unit: mismatch");
      $finish;
    end
  end

  // output back-pressure: random segments of differing density, plus long holds
  initial begin : receiver
    int unsigned seg_left;
    int unsigned pct;
    int unsigned hold_left;
    seg_left    = 0;
    pct         = 0;
    hold_left   = 0;
    out_stall_i = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_left == 0 && hold_ask != hold_served) begin
        hold_left = HOLD_CYCLES;
        hold_served++;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(10, 150);
          case ($urandom_range(3))
            0: pct = 0;
            1: pct = 25;
            2: pct = 50;
            default: pct = 85;
          endcase
        end
        seg_left--;
        out_stall_i <= ($urandom_range(99) < pct);
      end
    end
  end

  task automatic put(input mode_e m, input logic [7:0] b);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat (($urandom_range(4) == 0) ? $urandom_range(5, 25) : $urandom_range(1, 3))
        @(posedge clk_i);
      burst_left = ($urandom_range(7) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 20);
    end
    burst_left--;
    in_valid_i  <= 1'b1;
    mode_i      <= m;
    data_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (m == MODE_BYTE || m == MODE_EOF) items_sent++;
  endtask

  task automatic put_byte(input logic [7:0] b);
    put(MODE_BYTE, b);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (awaited_count != 0) @(posedge clk_i);
  endtask

  // receiver stops for a long stretch while the sender keeps offering items
  task automatic long_hold();
    hold_ask++;
    repeat (40) put_byte(8'($urandom_range(32, 126)));
  endtask

  task automatic utf8_sequence(input bit broken);
    int unsigned len;
    int unsigned cut;
    logic [7:0]  b;
    len = $urandom_range(2, 4);
    case (len)
      2: b = {3'b110, 5'($urandom)};
      3: b = {4'b1110, 4'($urandom)};
      default: b = {5'b11110, 3'($urandom)};
    endcase
    put_byte(b);
    cut = broken ? $urandom_range(1, len - 1) : len;
    for (int i = 1; i < len; i++) begin
      if (i == cut) begin
        b = 8'($urandom);
        if (b[7:6] == 2'b10) b[6] = 1'b1;
        put_byte(b);
        break;
      end
      put_byte({2'b10, 6'($urandom)});
    end
  endtask

  task automatic random_sequence();
    int unsigned pick;
    int unsigned len;
    pick = $urandom_range(99);
    if (pick < 12) begin
      put_byte(8'($urandom_range(32, 126)));
    end else if (pick < 27) begin
      utf8_sequence(1'b0);
    end else if (pick < 33) begin
      utf8_sequence(1'b1);
    end else if (pick < 37) begin
      put_byte($urandom_range(1) ? {2'b10, 6'($urandom)} : {5'b11111, 3'($urandom)});
    end else if (pick < 45) begin
      put_byte(CH_ESC);
      put_byte(8'($urandom));
    end else if (pick < 52) begin
      put_byte(CH_ESC);
      put_byte(CH_O);
      put_byte(8'($urandom));
    end else if (pick < 59) begin
      put_byte(CH_ESC);
      put_byte(CH_BR);
      put_byte(8'($urandom));
    end else if (pick < 66) begin
      put_byte(CH_ESC);
      put_byte(CH_BR);
      put_byte($urandom_range(1) ? CH_O : CH_BR);
      put_byte(8'($urandom));
    end else if (pick < 80) begin
      put_byte(CH_ESC);
      put_byte(CH_BR);
      len = $urandom_range(1, 4);
      repeat (len) put_byte(CH_ZERO + 8'($urandom_range(9)));
      put_byte($urandom_range(1) ? CH_TILDE : 8'($urandom));
    end else if (pick < 85) begin
      put_byte(CH_ESC);
      put(MODE_TIMEOUT, 8'($urandom));
    end else if (pick < 89) begin
      put($urandom_range(1) ? MODE_TIMEOUT : MODE_NONE, 8'($urandom));
    end else if (pick < 92) begin
      case ($urandom_range(2))
        0: ;
        1: begin
          put_byte(CH_ESC);
          put_byte(CH_BR);
        end
        default: put_byte({4'b1110, 4'($urandom)});
      endcase
      put(MODE_EOF, 8'($urandom));
    end else begin
      put_byte(8'($urandom));
    end
  endtask

  initial begin
    int milestone;
    milestone   = 400;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    mode_i      = MODE_BYTE;
    data_byte_i = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    put_byte(8'h00);
    put_byte(8'hFF);
    // largest code point the four-byte form can carry
    put_byte(8'hF7);
    put_byte(8'hBF);
    put_byte(8'hBF);
    put_byte(8'hBF);
    // bad continuation swallows the offending byte
    put_byte(8'hC3);
    put_byte(8'h41);
    put_byte(CH_ESC);
    put(MODE_TIMEOUT, 8'h00);
    put(MODE_TIMEOUT, 8'hFF);
    put(MODE_NONE, 8'hFF);
    put_byte(CH_ESC);
    put_byte(CH_O);
    put_byte(8'h50);
    // parameter saturates
    put_byte(CH_ESC);
    put_byte(CH_BR);
    put_byte(CH_NINE);
    put_byte(CH_NINE);
    put_byte(CH_NINE);
    put_byte(CH_TILDE);
    put_byte(CH_ESC);
    put(MODE_EOF, 8'h00);
    wait_drained();

    while (items_sent < ITEMS) begin
      random_sequence();
      if (items_sent >= milestone) begin
        if ((milestone / 400) % 2 == 1) long_hold();
        else wait_drained();
        milestone += 400;
      end
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("terminal_key_decoder_unit: match");
    end else begin
      $display("terminal_key_decoder_unit: mismatch");
    end
    $finish;
  end

endmodule
